// ----- rtl/huffman_table_encoder_macros.svh -----
// Assertion macros shared by the checker of the Huffman table encoder.
`ifndef HUFFMAN_TABLE_ENCODER_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_MACROS_SVH

// Clocked property, switched off while reset is held.
`define HTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds through reset.
`define HTE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/huf_pkg.sv -----
// Shared types, constants and helpers of the Huffman table encoder.
package huf_pkg;

    localparam int DEF_ALPHABET_SIZE = 256;
    localparam int DEF_COUNT_WIDTH   = 32;

    localparam int SYM_W        = 8;
    localparam int LEN_W        = 7;
    localparam int CODE_W       = 64;
    localparam int CODE_ENTRY_W = LEN_W + CODE_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(CODE_W);

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = 2;

    localparam logic [2:0] KIND_COUNT  = 3'd0;
    localparam logic [2:0] KIND_BUILD  = 3'd1;
    localparam logic [2:0] KIND_ENCODE = 3'd2;
    localparam logic [2:0] KIND_FLUSH  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    typedef enum logic [2:0] {
        OP_COUNT,
        OP_BUILD,
        OP_ENCODE,
        OP_FLUSH,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] sym;
        logic             in_range;
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CNT_WR,
        S_SORT_SCAN,
        S_MRG_RD_A,
        S_MRG_A,
        S_MRG_RD_B,
        S_MRG_B,
        S_DRV_RD,
        S_DRV_C0,
        S_DRV_C1,
        S_BUILD_END,
        S_ENC_LOAD,
        S_ENC_RUN,
        S_READ_OUT,
        S_FLUSH
    } t_eng_state;

    // Bit reversal: the first code bit lands in bit zero.
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

endpackage

// ----- rtl/huf_front.sv -----
// Front end: accepts items, classifies them and queues them for the engine.
module huf_front #(
    parameter int ALPHABET_SIZE = huf_pkg::DEF_ALPHABET_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0]          i_kind,
    input  logic [7:0]          i_symbol,
    output logic                o_stall,
    output logic                o_item_valid,
    output huf_pkg::t_item      o_item,
    input  logic                i_item_pop
);
    import huf_pkg::*;

    t_item          r_q [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    logic  accept, keep, push, in_range;
    t_item item;

    assign in_range = ({1'b0, i_symbol} < 9'(ALPHABET_SIZE));

    always_comb begin
        keep = 1'b0;
        item.op = OP_COUNT;
        item.sym = i_symbol;
        item.in_range = in_range;
        unique case (i_kind)
            KIND_COUNT: begin
                item.op = OP_COUNT;
                keep = in_range;
            end
            KIND_BUILD: begin
                item.op = OP_BUILD;
                keep = 1'b1;
            end
            KIND_ENCODE: begin
                item.op = OP_ENCODE;
                keep = in_range;
            end
            KIND_FLUSH: begin
                item.op = OP_FLUSH;
                keep = 1'b1;
            end
            KIND_READ: begin
                item.op = OP_READ;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall      = (r_cnt == (QAW+1)'(QUEUE_DEPTH));
    assign accept       = i_valid && !o_stall;
    assign push         = accept && keep;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_item_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (push && !i_item_pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (!push && i_item_pop) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/huf_engine.sv -----
// Back end: histogram, tree build, code table, bit packer and result register.
module huf_engine #(
    parameter int ALPHABET_SIZE = huf_pkg::DEF_ALPHABET_SIZE,
    parameter int COUNT_WIDTH   = huf_pkg::DEF_COUNT_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  huf_pkg::t_item              i_item,
    output logic                        o_item_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [7:0]                  o_out_byte,
    output logic                        o_byte_valid,
    output logic [2:0]                  o_fill_bits,
    output logic [huf_pkg::LEN_W-1:0]   o_code_length,
    output logic [huf_pkg::CODE_W-1:0]  o_code_word,
    output logic                        o_last
);
    import huf_pkg::*;

    localparam int SW  = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int NN  = ALPHABET_SIZE - 1;
    localparam int NW  = (NN > 1) ? $clog2(NN) : 1;
    localparam int CW  = COUNT_WIDTH;
    localparam int WW  = COUNT_WIDTH + 8;
    localparam int RW  = SW + 1;
    localparam int KW  = WW + SW;
    localparam int CTW = SW + 1;
    localparam logic [CTW-1:0] A_CNT = CTW'(ALPHABET_SIZE);
    localparam logic [CTW-1:0] ONE_C = CTW'(1);

    // storage
    logic [CW-1:0]           r_hist_mem  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_hist_vld;
    logic [CW-1:0]           r_hist_q;
    logic                    r_hist_q_vld;
    logic [CODE_ENTRY_W-1:0] r_code_mem  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_code_vld;
    logic [CODE_ENTRY_W-1:0] r_code_q;
    logic                    r_code_q_vld;
    logic [KW-1:0]           r_leaf_mem  [ALPHABET_SIZE];
    logic [KW-1:0]           r_leaf_q;
    logic [WW-1:0]           r_nw_mem    [NN];
    logic [WW-1:0]           r_nw_q;
    logic [2*RW-1:0]         r_nc_mem    [NN];
    logic [2*RW-1:0]         r_nc_q;
    logic [CODE_ENTRY_W-1:0] r_ncode_mem [NN];
    logic [CODE_ENTRY_W-1:0] r_ncode_q;

    // control and datapath registers
    t_eng_state              r_state, n_state;
    logic [SW-1:0]           r_sym, n_sym;
    logic                    r_in_range, n_in_range;
    logic [CTW-1:0]          r_scan_addr, n_scan_addr;
    logic                    r_scan_dv, n_scan_dv;
    logic [SW-1:0]           r_scan_sym, n_scan_sym;
    logic                    r_found, n_found;
    logic [KW-1:0]           r_best, n_best;
    logic                    r_have_last, n_have_last;
    logic [KW-1:0]           r_last, n_last;
    logic [CTW-1:0]          r_nl, n_nl, r_li, n_li, r_nh, n_nh, r_nn, n_nn, r_dn, n_dn;
    logic [WW-1:0]           r_wa, n_wa;
    logic [RW-1:0]           r_ra, n_ra;
    logic [2*RW-1:0]         r_kids, n_kids;
    logic [CODE_ENTRY_W-1:0] r_pcode, n_pcode;
    logic [7:0]              r_pend, n_pend;
    logic [2:0]              r_bp, n_bp;
    logic [CODE_W-1:0]       r_al, n_al;
    logic [LEN_W-1:0]        r_rem, n_rem;

    // memory ports
    logic [SW-1:0]           hist_raddr, hist_waddr;
    logic                    hist_we, hist_clr;
    logic [CW-1:0]           hist_wdata;
    logic [SW-1:0]           code_raddr, code_waddr;
    logic                    code_we, code_clr;
    logic [CODE_ENTRY_W-1:0] code_wdata;
    logic [SW-1:0]           leaf_raddr;
    logic                    leaf_we;
    logic [NW-1:0]           node_raddr;
    logic                    node_we;
    logic [NW-1:0]           ncode_waddr;
    logic                    ncode_we;

    // result register
    logic                    r_o_valid;
    logic [7:0]              r_o_byte;
    logic                    r_o_bvalid;
    logic [2:0]              r_o_fill;
    logic [LEN_W-1:0]        r_o_len;
    logic [CODE_W-1:0]       r_o_word;
    logic                    r_o_last;
    logic                    out_load, emit;
    logic [7:0]              e_byte;
    logic                    e_bvalid;
    logic [2:0]              e_fill;
    logic [LEN_W-1:0]        e_len;
    logic [CODE_W-1:0]       e_word;
    logic                    e_last;

    // helpers
    logic [CW-1:0]           cnt_cur, cnt_inc;
    logic [WW-1:0]           scan_w;
    logic [KW-1:0]           scan_key;
    logic                    scan_hit;
    logic                    leaf_av, node_av, pick_leaf;
    logic [WW-1:0]           leaf_w, pick_w;
    logic [RW-1:0]           pick_ref;
    logic [CTW:0]            qlen;
    logic                    is_root;
    logic [CODE_ENTRY_W-1:0] par, child_code;
    logic [RW-1:0]           child_ref;
    logic                    child_bit;
    logic [LEN_W-1:0]        par_len, child_len;
    logic [LEN_W-1:0]        ld_len;
    logic [CODE_W-1:0]       ld_word;
    logic [3:0]              room, take, bp_sum;
    logic [7:0]              take_mask, step_bits;
    logic [15:0]             step_shift;
    logic [7:0]              step_pend;
    logic                    step_full;
    logic [LEN_W-1:0]        rem_after;

    assign out_load = !r_o_valid || !i_stall;

    assign cnt_cur  = r_hist_q_vld ? r_hist_q : '0;
    assign cnt_inc  = (&cnt_cur) ? cnt_cur : cnt_cur + CW'(1);

    assign scan_w   = WW'(cnt_cur);
    assign scan_key = {scan_w, r_scan_sym};
    assign scan_hit = r_scan_dv && (scan_w != '0)
                      && (!r_have_last || (scan_key > r_last))
                      && (!r_found || (scan_key < r_best));

    assign leaf_av   = (r_li < r_nl);
    assign node_av   = (r_nh < r_nn);
    assign leaf_w    = r_leaf_q[KW-1:SW];
    assign pick_leaf = leaf_av && (!node_av || (leaf_w <= r_nw_q));
    assign pick_w    = pick_leaf ? leaf_w : r_nw_q;
    assign pick_ref  = pick_leaf ? {1'b0, r_leaf_q[SW-1:0]} : {1'b1, r_nh[SW-1:0]};
    assign qlen      = {1'b0, r_nl - r_li} + {1'b0, r_nn - r_nh};

    assign is_root    = (r_dn == r_nn - ONE_C);
    assign par        = (r_state == S_DRV_C0) ? (is_root ? '0 : r_ncode_q) : r_pcode;
    assign child_ref  = (r_state == S_DRV_C0) ? r_nc_q[RW-1:0] : r_kids[2*RW-1:RW];
    assign child_bit  = (r_state == S_DRV_C1);
    assign par_len    = par[CODE_ENTRY_W-1:CODE_W];
    assign child_len  = (par_len >= LEN_MAX) ? LEN_MAX : par_len + LEN_W'(1);
    assign child_code = {child_len, par[CODE_W-2:0], child_bit};

    assign ld_len  = r_code_q_vld ? r_code_q[CODE_ENTRY_W-1:CODE_W] : '0;
    assign ld_word = r_code_q_vld ? r_code_q[CODE_W-1:0] : '0;

    // packer step: move as many leading code bits as fit the pending byte
    assign room       = 4'd8 - {1'b0, r_bp};
    assign take       = (r_rem < LEN_W'(room)) ? r_rem[3:0] : room;
    assign take_mask  = 8'((9'd1 << take) - 9'd1);
    assign step_bits  = rev8(r_al[CODE_W-1:CODE_W-8]) & take_mask;
    assign step_shift = {8'd0, step_bits} << r_bp;
    assign step_pend  = r_pend | step_shift[7:0];
    assign bp_sum     = {1'b0, r_bp} + take;
    assign step_full  = bp_sum[3];
    assign rem_after  = r_rem - LEN_W'(take);

    always_comb begin
        n_state     = r_state;
        n_sym       = r_sym;
        n_in_range  = r_in_range;
        n_scan_addr = r_scan_addr;
        n_scan_dv   = r_scan_dv;
        n_scan_sym  = r_scan_sym;
        n_found     = r_found;
        n_best      = r_best;
        n_have_last = r_have_last;
        n_last      = r_last;
        n_nl        = r_nl;
        n_li        = r_li;
        n_nh        = r_nh;
        n_nn        = r_nn;
        n_dn        = r_dn;
        n_wa        = r_wa;
        n_ra        = r_ra;
        n_kids      = r_kids;
        n_pcode     = r_pcode;
        n_pend      = r_pend;
        n_bp        = r_bp;
        n_al        = r_al;
        n_rem       = r_rem;
        o_item_pop  = 1'b0;
        hist_raddr  = r_sym;
        hist_waddr  = r_sym;
        hist_wdata  = cnt_inc;
        hist_we     = 1'b0;
        hist_clr    = 1'b0;
        code_raddr  = r_sym;
        code_waddr  = child_ref[SW-1:0];
        code_wdata  = child_code;
        code_we     = 1'b0;
        code_clr    = 1'b0;
        leaf_raddr  = r_li[SW-1:0];
        leaf_we     = 1'b0;
        node_raddr  = r_nh[NW-1:0];
        node_we     = 1'b0;
        ncode_waddr = child_ref[NW-1:0];
        ncode_we    = 1'b0;
        emit        = 1'b0;
        e_byte      = '0;
        e_bvalid    = 1'b0;
        e_fill      = '0;
        e_len       = '0;
        e_word      = '0;
        e_last      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                hist_raddr = i_item.sym[SW-1:0];
                code_raddr = i_item.sym[SW-1:0];
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_sym      = i_item.sym[SW-1:0];
                    n_in_range = i_item.in_range;
                    unique case (i_item.op)
                        OP_COUNT:  n_state = S_CNT_WR;
                        OP_BUILD: begin
                            code_clr    = 1'b1;
                            n_nl        = '0;
                            n_have_last = 1'b0;
                            n_found     = 1'b0;
                            n_scan_addr = '0;
                            n_scan_dv   = 1'b0;
                            n_state     = S_SORT_SCAN;
                        end
                        OP_ENCODE: n_state = S_ENC_LOAD;
                        OP_FLUSH:  n_state = S_FLUSH;
                        OP_READ:   n_state = S_READ_OUT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CNT_WR: begin
                hist_we = 1'b1;
                n_state = S_IDLE;
            end
            S_SORT_SCAN: begin
                // one histogram entry a cycle; keep the smallest key above the last leaf
                if (r_scan_addr < A_CNT) begin
                    hist_raddr  = r_scan_addr[SW-1:0];
                    n_scan_addr = r_scan_addr + ONE_C;
                    n_scan_dv   = 1'b1;
                    n_scan_sym  = r_scan_addr[SW-1:0];
                end else begin
                    n_scan_dv = 1'b0;
                end
                if (scan_hit) begin
                    n_found = 1'b1;
                    n_best  = scan_key;
                end
                if ((r_scan_addr == A_CNT) && !r_scan_dv) begin
                    if (r_found) begin
                        leaf_we     = 1'b1;
                        n_nl        = r_nl + ONE_C;
                        n_last      = r_best;
                        n_have_last = 1'b1;
                        n_found     = 1'b0;
                        n_scan_addr = '0;
                    end else if (r_nl == ONE_C) begin
                        // lone symbol: code 0 of length 1
                        code_we    = 1'b1;
                        code_waddr = r_last[SW-1:0];
                        code_wdata = {LEN_W'(1), CODE_W'(0)};
                        n_state    = S_BUILD_END;
                    end else if (r_nl == '0) begin
                        n_state = S_BUILD_END;
                    end else begin
                        n_li    = '0;
                        n_nh    = '0;
                        n_nn    = '0;
                        n_state = S_MRG_RD_A;
                    end
                end
            end
            S_MRG_RD_A: begin
                if (qlen < (CTW+1)'(2)) begin
                    n_dn    = r_nn - ONE_C;
                    n_state = S_DRV_RD;
                end else begin
                    n_state = S_MRG_A;
                end
            end
            S_MRG_A: begin
                n_wa = pick_w;
                n_ra = pick_ref;
                if (pick_leaf) begin
                    n_li = r_li + ONE_C;
                end else begin
                    n_nh = r_nh + ONE_C;
                end
                n_state = S_MRG_RD_B;
            end
            S_MRG_RD_B: begin
                n_state = S_MRG_B;
            end
            S_MRG_B: begin
                node_we = 1'b1;
                if (pick_leaf) begin
                    n_li = r_li + ONE_C;
                end else begin
                    n_nh = r_nh + ONE_C;
                end
                n_nn    = r_nn + ONE_C;
                n_state = S_MRG_RD_A;
            end
            S_DRV_RD: begin
                node_raddr = r_dn[NW-1:0];
                n_state    = S_DRV_C0;
            end
            S_DRV_C0, S_DRV_C1: begin
                node_raddr = r_dn[NW-1:0];
                if (child_ref[RW-1]) begin
                    ncode_we = 1'b1;
                end else begin
                    code_we = 1'b1;
                end
                if (r_state == S_DRV_C0) begin
                    n_kids  = r_nc_q;
                    n_pcode = par;
                    n_state = S_DRV_C1;
                end else if (r_dn == '0) begin
                    n_state = S_BUILD_END;
                end else begin
                    n_dn    = r_dn - ONE_C;
                    n_state = S_DRV_RD;
                end
            end
            S_BUILD_END: begin
                hist_clr = 1'b1;
                n_state  = S_IDLE;
            end
            S_ENC_LOAD: begin
                // left-align the code so the root bit sits at the top
                n_al    = ld_word << (LEN_MAX - ld_len);
                n_rem   = ld_len;
                n_state = S_ENC_RUN;
            end
            S_ENC_RUN: begin
                if (r_rem == '0) begin
                    n_state = S_IDLE;
                end else if (!step_full || out_load) begin
                    n_al  = r_al << take;
                    n_rem = rem_after;
                    if (step_full) begin
                        emit     = 1'b1;
                        e_byte   = step_pend;
                        e_bvalid = 1'b1;
                        e_last   = (rem_after < LEN_W'(8));
                        n_pend   = '0;
                        n_bp     = '0;
                    end else begin
                        n_pend = step_pend;
                        n_bp   = bp_sum[2:0];
                    end
                    if (rem_after == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ_OUT: begin
                if (out_load) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (r_in_range) begin
                        e_len  = ld_len;
                        e_word = ld_word;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_load) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (r_bp != '0) begin
                        e_byte   = r_pend;
                        e_bvalid = 1'b1;
                        e_fill   = 3'(4'd8 - {1'b0, r_bp});
                    end
                    n_pend  = '0;
                    n_bp    = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_waddr] <= hist_wdata;
        end
        r_hist_q <= r_hist_mem[hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (code_we) begin
            r_code_mem[code_waddr] <= code_wdata;
        end
        r_code_q <= r_code_mem[code_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            r_leaf_mem[r_nl[SW-1:0]] <= r_best;
        end
        r_leaf_q <= r_leaf_mem[leaf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_nw_mem[r_nn[NW-1:0]] <= r_wa + pick_w;
            r_nc_mem[r_nn[NW-1:0]] <= {pick_ref, r_ra};
        end
        r_nw_q <= r_nw_mem[node_raddr];
        r_nc_q <= r_nc_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ncode_we) begin
            r_ncode_mem[ncode_waddr] <= child_code;
        end
        r_ncode_q <= r_ncode_mem[node_raddr];
    end

    // valid bits stand in for the cleared histogram and code table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld   <= '0;
            r_code_vld   <= '0;
            r_hist_q_vld <= 1'b0;
            r_code_q_vld <= 1'b0;
        end else begin
            r_hist_q_vld <= r_hist_vld[hist_raddr];
            r_code_q_vld <= r_code_vld[code_raddr];
            if (hist_clr) begin
                r_hist_vld <= '0;
            end else if (hist_we) begin
                r_hist_vld[hist_waddr] <= 1'b1;
            end
            if (code_clr) begin
                r_code_vld <= '0;
            end else if (code_we) begin
                r_code_vld[code_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_addr <= '0;
            r_scan_dv   <= 1'b0;
            r_found     <= 1'b0;
            r_have_last <= 1'b0;
            r_nl        <= '0;
            r_li        <= '0;
            r_nh        <= '0;
            r_nn        <= '0;
            r_dn        <= '0;
            r_pend      <= '0;
            r_bp        <= '0;
            r_rem       <= '0;
        end else begin
            r_state     <= n_state;
            r_scan_addr <= n_scan_addr;
            r_scan_dv   <= n_scan_dv;
            r_found     <= n_found;
            r_have_last <= n_have_last;
            r_nl        <= n_nl;
            r_li        <= n_li;
            r_nh        <= n_nh;
            r_nn        <= n_nn;
            r_dn        <= n_dn;
            r_pend      <= n_pend;
            r_bp        <= n_bp;
            r_rem       <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_in_range <= n_in_range;
        r_scan_sym <= n_scan_sym;
        r_best     <= n_best;
        r_last     <= n_last;
        r_wa       <= n_wa;
        r_ra       <= n_ra;
        r_kids     <= n_kids;
        r_pcode    <= n_pcode;
        r_al       <= n_al;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_byte   <= e_byte;
            r_o_bvalid <= e_bvalid;
            r_o_fill   <= e_fill;
            r_o_len    <= e_len;
            r_o_word   <= e_word;
            r_o_last   <= e_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_byte_valid  = r_o_bvalid;
    assign o_fill_bits   = r_o_fill;
    assign o_code_length = r_o_len;
    assign o_code_word   = r_o_word;
    assign o_last        = r_o_last;

endmodule

// ----- rtl/huffman_table_encoder.sv -----
// Top level of the static Huffman byte encoder.
//
// Input channel (i_valid / o_stall) carries one command per transfer: count a
// byte, build the code table, encode a byte, flush the packer, or read a code
// entry. Unknown kinds and out-of-alphabet bytes for count or encode are
// dropped at the front. Output channel (o_valid / i_stall) carries results;
// o_last marks the final result of a command.
// A four-entry command queue parts the input port from the engine, and a
// result register parts the engine from the output port, so commands keep
// flowing in while a result waits on a stalled receiver.
// Engine work per command, after the command queue:
//   count does a histogram read-modify-write, read does a table read,
//   flush emits the pending bits, encode reads the table and runs packer steps
//   (one step for an unused byte; a step moves up to 8 bits and completes at
//   most one result, so a 64-bit code takes up to 9 steps), build runs L+1
//   leaf sort scans over the histogram for L used symbols, then L-1 merges and
//   the code derivation of each of the L-1 merged nodes.
// A stalled receiver holds the result register; the engine waits, then the
// queue fills and o_stall rises.
// Reset (synchronous, i_rst_n low) empties the queue, clears the packer and
// drops the histogram and code table through valid bits; no clearing pass.
module huffman_table_encoder #(
    parameter int ALPHABET_SIZE = huf_pkg::DEF_ALPHABET_SIZE,
    parameter int COUNT_WIDTH   = huf_pkg::DEF_COUNT_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [2:0]                  i_kind,
    input  logic [7:0]                  i_symbol,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_out_byte,
    output logic                        o_byte_valid,
    output logic [2:0]                  o_fill_bits,
    output logic [huf_pkg::LEN_W-1:0]   o_code_length,
    output logic [huf_pkg::CODE_W-1:0]  o_code_word,
    output logic                        o_last
);
    import huf_pkg::*;

    t_item item;
    logic  item_valid, item_pop;

    // classify and queue commands
    huf_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_kind       (i_kind),
        .i_symbol     (i_symbol),
        .o_stall      (o_stall),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    // execute commands and drive results
    huf_engine #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_fill_bits   (o_fill_bits),
        .o_code_length (o_code_length),
        .o_code_word   (o_code_word),
        .o_last        (o_last)
    );

endmodule

// ----- rtl/huf_checker.sv -----
// Port-level checker of the Huffman table encoder, bound to the top level.
`include "huffman_table_encoder_macros.svh"

module huf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic [2:0]  i_kind,
    input logic [7:0]  i_symbol,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_byte_valid,
    input logic [2:0]  o_fill_bits,
    input logic [6:0]  o_code_length,
    input logic [63:0] o_code_word,
    input logic        o_last
);

    `HTE_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid && $stable(i_kind) && $stable(i_symbol), "command changed while stalled")
    `HTE_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_code_word) && $stable(o_last), "result changed while stalled")
    `HTE_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")
    `HTE_ASSERT(a_fill_flush, i_clk, i_rst_n, o_valid && (o_fill_bits != 3'd0) |-> o_byte_valid && o_last && (o_code_length == 7'd0), "padding outside a flush result")
    `HTE_ASSERT(a_read_shape, i_clk, i_rst_n, o_valid && (o_code_length != 7'd0) |-> !o_byte_valid && o_last && (o_code_length <= 7'd64), "malformed code read result")

endmodule

bind huffman_table_encoder huf_checker u_huf_checker (.*);
